// ===== hw/rtl/rttybtd_pkg.sv =====
// rttybtd_pkg: shared widths, register indexes, alu request/response types
// and the frame-check result type for the rtty bit-timing decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rttybtd_pkg;

    // field and state widths
    localparam int TICK_W     = 16;
    localparam int CFG_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int RUN_W      = 32;
    localparam int CNT_W      = 5;
    localparam int CODE_W     = 5;
    localparam int FRAME_BITS = 8;
    localparam int MAX_RES    = 3;
    localparam int RES_W      = 2;

    localparam logic [CNT_W-1:0] CNT_MAX    = 5'd31;
    localparam logic [CFG_W-1:0] SYM_RESET  = 15'd11249;
    localparam logic [CFG_W-1:0] SW_RESET   = 15'd2812;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH = 2'd1;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic [RUN_W-1:0] a;
        logic [RUN_W-1:0] b;
        t_alu_op          op;
    } t_alu_req;

    typedef struct packed {
        logic [RUN_W-1:0] sum_sat;  // saturating a + b
        logic [RUN_W-1:0] diff;     // a - b, wrapping
        logic             gt;       // a > b
    } t_alu_rsp;

    typedef struct packed {
        logic              hit;
        logic [CODE_W-1:0] code;
    } t_frame;

    function automatic logic [CODE_W-1:0] rev5(input logic [CODE_W-1:0] v);
        logic [CODE_W-1:0] r;
        for (int i = 0; i < CODE_W; i++) begin
            r[CODE_W-1-i] = v[i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rttybtd_if.sv =====
// rttybtd_if: valid/ready channel interfaces for input items, result items
// and configuration writes; depends on rttybtd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rttybtd_in_if import rttybtd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              level_is_space;
    logic [TICK_W-1:0] elapsed_ticks;

    modport source (output valid, output level_is_space, output elapsed_ticks, input ready);
    modport sink   (input valid, input level_is_space, input elapsed_ticks, output ready);
endinterface

interface rttybtd_out_if import rttybtd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] baudot_code;
    logic              last_of_run;

    modport source (output valid, output baudot_code, output last_of_run, input ready);
    modport sink   (input valid, input baudot_code, input last_of_run, output ready);
endinterface

interface rttybtd_cfg_if import rttybtd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rttybtd_alu.sv =====
// rttybtd_alu: shared 32-bit add/subtract unit with saturation and compare
// depends on rttybtd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rttybtd_alu import rttybtd_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [RUN_W-1:0] w_b;
    logic [RUN_W:0]   w_raw;

    assign w_b   = (i_req.op == ALU_SUB) ? ~i_req.b : i_req.b;
    assign w_raw = {1'b0, i_req.a} + {1'b0, w_b} + {{RUN_W{1'b0}}, (i_req.op == ALU_SUB)};

    // add: carry out means overflow; sub: carry out means no borrow
    assign o_rsp.sum_sat = w_raw[RUN_W] ? {RUN_W{1'b1}} : w_raw[RUN_W-1:0];
    assign o_rsp.diff    = w_raw[RUN_W-1:0];
    assign o_rsp.gt      = w_raw[RUN_W] && (w_raw[RUN_W-1:0] != '0);

endmodule

`default_nettype wire

// ===== hw/rtl/rttybtd_frame_check.sv =====
// rttybtd_frame_check: picks the 8-bit window ending at the current bit count
// out of the bit history and checks start/stop bits; depends on rttybtd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rttybtd_frame_check import rttybtd_pkg::*; #(
    parameter int HISTORY_BITS = 16
) (
    input  logic [HISTORY_BITS-1:0] i_hist,
    input  logic [CNT_W-1:0]        i_count,
    output t_frame                  o_frame
);

    logic [CNT_W-1:0]           w_over;
    logic [HISTORY_BITS+31:0]   w_ext;
    logic [FRAME_BITS-1:0]      w_win;

    // bits above the history width read as zero
    assign w_over = i_count - CNT_W'(FRAME_BITS);
    assign w_ext  = {32'd0, i_hist} >> w_over;
    assign w_win  = w_ext[FRAME_BITS-1:0];

    // two stop bits at the bottom, start bit (space) at the top
    assign o_frame.hit  = (w_win[1:0] == 2'b11) && !w_win[FRAME_BITS-1];
    assign o_frame.code = rev5(w_win[6:2]);

endmodule

`default_nettype wire

// ===== hw/rtl/rtty_bit_timing_decoder.sv =====
// rtty_bit_timing_decoder: top level, sequencer around one shared alu,
// run-to-bit conversion, frame search and result buffer
// depends on rttybtd_pkg, rttybtd_if, rttybtd_alu, rttybtd_frame_check
//
//  channel  | dir | payload                              | item
//  ---------+-----+--------------------------------------+---------------------------
//  i_in     | in  | level_is_space, elapsed_ticks[15:0]  | one detector decision
//  o_out    | out | baudot_code[4:0], last_of_run        | one decoded character
//  i_cfg    | in  | index[1:0], data[14:0]               | register write, always ready
//
//  steps: accept, the level/run update (pend, compare, move, old-run trim,
//  run add), a check and a subtract per converted bit up to MAX_RUN_BITS, the
//  run close, the frame search step by step, then each result handed to the
//  output register; the worst item is set by the bit loop on the shared alu
//  (one alu operation per update and conversion cycle)
//  reset: synchronous, restores defaults and control state, not result data; no clearing pass
//  stalls: i_in is taken only in idle; a stalled o_out holds the drain of the
//  result buffer, and the last result may wait in the output register while
//  the next item is accepted
`timescale 1ns / 1ps
`default_nettype none

module rtty_bit_timing_decoder import rttybtd_pkg::*; #(
    parameter int HISTORY_BITS = 16,
    parameter int MAX_RUN_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rttybtd_in_if.sink           i_in,
    rttybtd_out_if.source        o_out,
    rttybtd_cfg_if.sink          i_cfg
);

    localparam int NB_W = $clog2(MAX_RUN_BITS + 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_PEND   = 10'b0000000010,
        S_CMP    = 10'b0000000100,
        S_MOVE   = 10'b0000001000,
        S_SUBOLD = 10'b0000010000,
        S_RUN    = 10'b0000100000,
        S_CHK    = 10'b0001000000,
        S_SUB    = 10'b0010000000,
        S_SRCH   = 10'b0100000000,
        S_DRAIN  = 10'b1000000000
    } t_state;

    // control and run state
    t_state                  r_state, n_state;
    logic [CFG_W-1:0]        r_sym, n_sym;
    logic [CFG_W-1:0]        r_sw, n_sw;
    logic                    r_level, n_level;      // 1 mark, 0 space
    logic                    r_now_mark, n_now_mark;
    logic [TICK_W-1:0]       r_t, n_t;
    logic [RUN_W-1:0]        r_pend, n_pend;
    logic [RUN_W-1:0]        r_mark_run, n_mark_run;
    logic [RUN_W-1:0]        r_space_run, n_space_run;
    logic [HISTORY_BITS-1:0] r_hist, n_hist;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_conv, n_conv;
    logic [NB_W-1:0]         r_nbits, n_nbits;
    logic [RES_W-1:0]        r_nres, n_nres;
    logic [RES_W-1:0]        r_didx, n_didx;

    // result buffer and output register
    logic [CODE_W-1:0]       r_buf [MAX_RES];
    logic                    r_out_valid, n_out_valid;
    logic [CODE_W-1:0]       r_out_code;
    logic                    r_out_last;

    t_alu_req                w_alu_req;
    t_alu_rsp                w_alu_rsp;
    t_frame                  w_frame;
    logic [RUN_W-1:0]        w_t_ext;
    logic [RUN_W-1:0]        w_conv_run;
    logic [RUN_W-1:0]        w_cur_run;
    logic                    w_conv_bit;
    logic                    w_cnt_ge8;
    logic                    w_take;
    logic                    w_load;
    logic                    w_last;
    logic [CNT_W-1:0]        w_cnt_inc;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_out_valid;
    assign o_out.baudot_code = r_out_code;
    assign o_out.last_of_run = r_out_last;

    assign w_t_ext = {{(RUN_W-TICK_W){1'b0}}, r_t};

    // after a switch the closed run belongs to the level just left
    assign w_conv_run = r_level ? r_space_run : r_mark_run;
    assign w_cur_run  = r_level ? r_mark_run : r_space_run;
    assign w_conv_bit = ~r_level;

    assign w_cnt_ge8 = (r_cnt >= CNT_W'(FRAME_BITS));
    assign w_take    = w_cnt_ge8 && w_frame.hit && (r_nres < RES_W'(MAX_RES));
    assign w_load    = (r_state == S_DRAIN) && (!r_out_valid || o_out.ready);
    assign w_last    = ((r_didx + RES_W'(1)) == r_nres);
    assign w_cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_W'(1);

    // operand selection for the shared unit
    always_comb begin
        w_alu_req.a  = r_pend;
        w_alu_req.b  = w_t_ext;
        w_alu_req.op = ALU_ADD;
        case (r_state)
            S_PEND: begin
                w_alu_req.a  = r_pend;
                w_alu_req.b  = w_t_ext;
                w_alu_req.op = ALU_ADD;
            end
            S_CMP: begin
                w_alu_req.a  = r_pend;
                w_alu_req.b  = {{(RUN_W-CFG_W){1'b0}}, r_sw};
                w_alu_req.op = ALU_SUB;
            end
            S_MOVE: begin
                w_alu_req.a  = r_pend;
                w_alu_req.b  = w_t_ext;
                w_alu_req.op = ALU_SUB;
            end
            S_SUBOLD: begin
                w_alu_req.a  = w_cur_run;
                w_alu_req.b  = r_pend;
                w_alu_req.op = ALU_SUB;
            end
            S_RUN: begin
                w_alu_req.a  = w_cur_run;
                w_alu_req.b  = w_t_ext;
                w_alu_req.op = ALU_ADD;
            end
            S_CHK: begin
                // compare against half a symbol
                w_alu_req.a  = w_conv_run;
                w_alu_req.b  = {{(RUN_W-CFG_W+1){1'b0}}, r_sym[CFG_W-1:1]};
                w_alu_req.op = ALU_SUB;
            end
            S_SUB: begin
                w_alu_req.a  = w_conv_run;
                w_alu_req.b  = {{(RUN_W-CFG_W){1'b0}}, r_sym};
                w_alu_req.op = ALU_SUB;
            end
            default: begin
                w_alu_req.a  = r_pend;
                w_alu_req.b  = w_t_ext;
                w_alu_req.op = ALU_ADD;
            end
        endcase
    end

    rttybtd_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    rttybtd_frame_check #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_frame_check (
        .i_hist  (r_hist),
        .i_count (r_cnt),
        .o_frame (w_frame)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_sym       = r_sym;
        n_sw        = r_sw;
        n_level     = r_level;
        n_now_mark  = r_now_mark;
        n_t         = r_t;
        n_pend      = r_pend;
        n_mark_run  = r_mark_run;
        n_space_run = r_space_run;
        n_hist      = r_hist;
        n_cnt       = r_cnt;
        n_conv      = r_conv;
        n_nbits     = r_nbits;
        n_nres      = r_nres;
        n_didx      = r_didx;

        // the user must make register writes only while idle; the block does not enforce it
        if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_SYMBOL: n_sym = i_cfg.data;
                REG_SWITCH: n_sw  = i_cfg.data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_now_mark = ~i_in.level_is_space;
                    n_t        = i_in.elapsed_ticks;
                    n_nres     = '0;
                    n_conv     = 1'b0;
                    n_state    = S_PEND;
                end
            end
            S_PEND: begin
                if (r_now_mark == r_level) begin
                    n_pend  = '0;
                    n_state = S_RUN;
                end else begin
                    n_pend  = w_alu_rsp.sum_sat;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = w_alu_rsp.gt ? S_MOVE : S_RUN;
            end
            S_MOVE: begin
                // ticks pending before this item start the new run
                n_pend = w_alu_rsp.diff;
                if (r_level) begin
                    n_space_run = w_alu_rsp.diff;
                end else begin
                    n_mark_run = w_alu_rsp.diff;
                end
                n_state = S_SUBOLD;
            end
            S_SUBOLD: begin
                // and leave the old run, saturating at zero
                if (r_level) begin
                    n_mark_run = w_alu_rsp.gt ? w_alu_rsp.diff : '0;
                end else begin
                    n_space_run = w_alu_rsp.gt ? w_alu_rsp.diff : '0;
                end
                n_level = r_now_mark;
                n_pend  = '0;
                n_conv  = 1'b1;
                n_state = S_RUN;
            end
            S_RUN: begin
                if (r_level) begin
                    n_mark_run = w_alu_rsp.sum_sat;
                end else begin
                    n_space_run = w_alu_rsp.sum_sat;
                end
                n_nbits = '0;
                n_state = r_conv ? S_CHK : S_SRCH;
            end
            S_CHK: begin
                if ((r_nbits < NB_W'(MAX_RUN_BITS)) && w_alu_rsp.gt) begin
                    n_hist  = {r_hist[HISTORY_BITS-2:0], w_conv_bit};
                    n_cnt   = w_cnt_inc;
                    n_nbits = r_nbits + NB_W'(1);
                    n_state = S_SUB;
                end else begin
                    if (r_level) begin
                        n_space_run = '0;
                    end else begin
                        n_mark_run = '0;
                    end
                    n_state = S_SRCH;
                end
            end
            S_SUB: begin
                if (w_alu_rsp.gt) begin
                    if (r_level) begin
                        n_space_run = w_alu_rsp.diff;
                    end else begin
                        n_mark_run = w_alu_rsp.diff;
                    end
                    n_state = S_CHK;
                end else begin
                    // last partial symbol ends the run
                    if (r_level) begin
                        n_space_run = '0;
                    end else begin
                        n_mark_run = '0;
                    end
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if (w_cnt_ge8) begin
                    if (w_take) begin
                        n_nres = r_nres + RES_W'(1);
                        n_cnt  = r_cnt - CNT_W'(FRAME_BITS);
                    end else begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end else begin
                    n_didx  = '0;
                    n_state = (r_nres != '0) ? S_DRAIN : S_IDLE;
                end
            end
            S_DRAIN: begin
                if (w_load) begin
                    n_didx = r_didx + RES_W'(1);
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sym       <= SYM_RESET;
            r_sw        <= SW_RESET;
            r_level     <= 1'b1;
            r_now_mark  <= 1'b1;
            r_t         <= '0;
            r_pend      <= '0;
            r_mark_run  <= '0;
            r_space_run <= '0;
            r_hist      <= '0;
            r_cnt       <= '0;
            r_conv      <= 1'b0;
            r_nbits     <= '0;
            r_nres      <= '0;
            r_didx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sym       <= n_sym;
            r_sw        <= n_sw;
            r_level     <= n_level;
            r_now_mark  <= n_now_mark;
            r_t         <= n_t;
            r_pend      <= n_pend;
            r_mark_run  <= n_mark_run;
            r_space_run <= n_space_run;
            r_hist      <= n_hist;
            r_cnt       <= n_cnt;
            r_conv      <= n_conv;
            r_nbits     <= n_nbits;
            r_nres      <= n_nres;
            r_didx      <= n_didx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_code <= r_buf[r_didx];
            r_out_last <= w_last;
        end
        if ((r_state == S_SRCH) && w_take) begin
            r_buf[r_nres] <= w_frame.code;
        end
    end

    // conversion never produces more than the per-run bit limit
    a_nbits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nbits <= NB_W'(MAX_RUN_BITS))
        else $error("run bit counter beyond limit");

    // drain only reads filled buffer entries
    a_drain_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_didx < r_nres))
        else $error("drain index past buffered results");

    // a partial last symbol leaves the closed run empty
    a_conv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUB && !w_alu_rsp.gt) |=> (w_conv_run == '0))
        else $error("closed run not cleared after conversion");

    // a found frame consumes exactly one window of bits
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH && w_take) |=> (r_cnt == $past(r_cnt) - CNT_W'(FRAME_BITS)))
        else $error("bit count not reduced by a frame");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// tb_top: self-checking bench for rtty_bit_timing_decoder, built around a
// bit-exact deframer predictor, random idling on both channels and timing phases
// depends on rttybtd_pkg, rttybtd_if and the decoder rtl
`timescale 1ns / 1ps

module tb_top;
    import rttybtd_pkg::*;

    localparam int RUN_BITS_MAX = 24;    // bits per converted run, as built
    localparam int HIST_W       = 16;    // history width, as built
    // worst item: accept, the level/run update, a full run's conversion, the
    // frame search and 3 results; set well clear of that
    localparam int SETTLE       = 120;
    // longest legal quiet stretch is the long receiver hold plus one worst item
    // and both sides' longest waits; several times over
    localparam int LONG_HOLD    = 1500;
    localparam int STALL_LIMIT  = 8000;
    localparam int RAND_ITEMS   = 200;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_baudot;

    logic i_clk;
    logic i_rst_n;

    rttybtd_in_if  in_ch  ();
    rttybtd_out_if out_ch ();
    rttybtd_cfg_if cfg_ch ();

    rtty_bit_timing_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predictor copy of the registers and the deframer state
    logic [CFG_W-1:0]  sym_ticks;
    logic [CFG_W-1:0]  sw_ticks;
    logic              on_mark;
    logic [31:0]       pend_ticks;
    logic [31:0]       mark_ticks;
    logic [31:0]       space_ticks;
    logic [HIST_W-1:0] hist;
    logic [4:0]        nbits;

    // characters predicted but not yet seen at the output, oldest first
    t_baudot baudot_due[$];

    int n_errors    = 0;
    int items_sent  = 0;
    int rx_hold     = 0;     // one-off long hold asked of the receiver
    int tx_burst    = 0;     // items left in a no-gap stretch, sender side
    int rx_burst    = 0;     // same, receiver side
    int idle_cycles = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] sub_floor(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a - b : 32'd0;
    endfunction

    // turn a closed run into bits of its level, one per symbol time while
    // more than half a symbol is left; the run is always emptied
    task automatic shift_run(inout logic [31:0] run, input logic lvl);
        logic [31:0] sym;
        logic [31:0] half;
        int          n;
        sym  = {17'd0, sym_ticks};
        half = sym >> 1;
        n    = 0;
        while (n < RUN_BITS_MAX && run > half) begin
            hist = {hist[HIST_W-2:0], lvl};
            if (nbits != 5'd31) begin
                nbits = nbits + 5'd1;
            end
            n++;
            // last partial symbol ends the run
            if (run <= sym) begin
                run = 32'd0;
                break;
            end
            run = run - sym;
        end
        run = 32'd0;
    endtask

    // one detector decision in, zero to three characters out
    task automatic deframe_item(input logic lvl_space, input logic [TICK_W-1:0] t);
        logic [31:0]       tt;
        logic [31:0]       moved;
        logic [31:0]       win;
        logic [CODE_W-1:0] rc;
        logic              now_mark;
        logic              close_mark;
        logic              close_space;
        t_baudot           found[MAX_RES];
        int                n;
        int                over;
        tt          = {16'd0, t};
        now_mark    = ~lvl_space;
        close_mark  = 1'b0;
        close_space = 1'b0;
        n           = 0;
        if (now_mark == on_mark) begin
            pend_ticks = 32'd0;
        end else begin
            pend_ticks = add_sat(pend_ticks, tt);
            if (pend_ticks > {17'd0, sw_ticks}) begin
                // switch accepted: earlier pending ticks change sides
                moved = pend_ticks - tt;
                if (on_mark) begin
                    space_ticks = moved;
                    mark_ticks  = sub_floor(mark_ticks, moved);
                    close_mark  = 1'b1;
                end else begin
                    mark_ticks  = moved;
                    space_ticks = sub_floor(space_ticks, moved);
                    close_space = 1'b1;
                end
                on_mark    = now_mark;
                pend_ticks = 32'd0;
            end
        end
        if (on_mark) begin
            mark_ticks = add_sat(mark_ticks, tt);
        end else begin
            space_ticks = add_sat(space_ticks, tt);
        end
        if (close_mark) begin
            shift_run(mark_ticks, 1'b1);
        end
        if (close_space) begin
            shift_run(space_ticks, 1'b0);
        end
        // frame search from the oldest window down; bits above the history read zero
        while (nbits >= 5'd8) begin
            over = int'(nbits) - 8;
            win  = {16'd0, hist} >> over;
            if (win[1:0] == 2'b11 && !win[7] && n < MAX_RES) begin
                for (int i = 0; i < CODE_W; i++) begin
                    rc[i] = win[6-i];
                end
                found[n].code = rc;
                found[n].last = 1'b0;
                n++;
                nbits = nbits - 5'd8;
            end else begin
                nbits = nbits - 5'd1;
            end
        end
        for (int i = 0; i < n; i++) begin
            found[i].last = (i == n - 1);
            baudot_due.push_back(found[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // random wait per item, with now and then a stretch of back-to-back items
    function automatic int pick_wait(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            burst_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [CODE_W-1:0] rand_code();
        return CODE_W'($urandom_range(0, 31));
    endfunction

    // valid is left high on return so that a following item with no gap
    // does not lower and raise it in the same step
    task automatic send_item(input logic lvl_space, input int t);
        int gap;
        gap = pick_wait(tx_burst);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.level_is_space <= lvl_space;
        in_ch.elapsed_ticks  <= t[TICK_W-1:0];
        do @(posedge i_clk); while (!in_ch.ready);
        deframe_item(lvl_space, t[TICK_W-1:0]);
        items_sent++;
    endtask

    // start bit, five data bits lsb first, two stop bits; each bit is cut
    // into up to max_split items; a spoilt character loses its start bit or
    // one stop bit
    task automatic send_char(input logic [CODE_W-1:0] code, input logic spoil,
                             input logic jitter, input int max_split);
        logic [7:0] frame;
        int         sym;
        int         len;
        int         m;
        int         part;
        sym   = int'(sym_ticks);
        frame = {2'b11, code, 1'b0};
        if (spoil) begin
            if ($urandom_range(0, 1) == 0) begin
                frame[0] = 1'b1;
            end else begin
                frame[6 + $urandom_range(0, 1)] = 1'b0;
            end
        end
        for (int b = 0; b < 8; b++) begin
            len = sym;
            if (jitter) begin
                len = len + int'($urandom_range(0, sym / 4)) - sym / 8;
            end
            m = $urandom_range(1, max_split);
            for (int k = 0; k < m; k++) begin
                part = (k == m - 1) ? len - (m - 1) * (len / m) : len / m;
                send_item(!frame[b], part);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == REG_SYMBOL) begin
            sym_ticks = val;
        end else if (idx == REG_SWITCH) begin
            sw_ticks = val;
        end
    endtask

    // stop offering, wait for every due character, then let an item that
    // gives no character run out
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (baudot_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_timing(input int sym, input int sw);
        wait_idle();
        write_reg(REG_SYMBOL, sym[CFG_W-1:0]);
        write_reg(REG_SWITCH, sw[CFG_W-1:0]);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset timing: tick extremes, a glitch below switch time, runs past the
    // bit limit of both levels, one clean character
    task automatic test_directed();
        send_item(1'b0, 0);              // mark, nothing elapsed
        send_item(1'b1, 0);              // zero-length space, no switch
        send_item(1'b1, 1000);           // short space glitch, still pending
        send_item(1'b0, 65535);          // back to mark clears the pending ticks
        send_item(1'b1, 65535);          // switch to space, closes the mark run
        send_item(1'b0, 65535);          // switch back, space run of several bits
        repeat (4) send_item(1'b0, 65535);   // mark run past the bit limit
        send_item(1'b1, 20000);
        repeat (4) send_item(1'b1, 65535);   // space run past the bit limit
        send_item(1'b0, 22498);
        send_char(5'b10110, 1'b0, 1'b0, 1);
        send_item(1'b1, 11249);          // next start bit frames the character
        wait_idle();
    endtask

    // register extremes, including a symbol time of zero
    task automatic test_timing_extremes();
        set_timing(32767, 32767);
        repeat (2) send_char(rand_code(), 1'b0, 1'b0, 2);
        send_item(1'b1, 65535);
        send_item(1'b0, 65535);
        send_item(1'b1, 65535);

        set_timing(1, 0);
        repeat (3) send_char(rand_code(), 1'b0, 1'b1, 2);
        send_item(1'b1, 1);

        // every non-empty run gives the full bit limit
        set_timing(0, 0);
        send_item(1'b1, 5);
        send_item(1'b0, 0);
        send_item(1'b0, 7);
        send_item(1'b1, 65535);

        set_timing(32767, 0);
        repeat (2) send_char(rand_code(), 1'b0, 1'b1, 2);
        send_item(1'b1, 32767);
        wait_idle();
    endtask

    // random timing phases: mostly well-formed characters with random codes
    // and jitter, some spoilt frames and some raw noise
    task automatic test_random_traffic();
        int start_items;
        int phase_start;
        int sym;
        int pick;
        start_items = items_sent;
        while (items_sent - start_items < RAND_ITEMS) begin
            sym = $urandom_range(8, 20000);
            set_timing(sym, $urandom_range(0, sym / 2));
            phase_start = items_sent;
            while (items_sent - phase_start < 80 && items_sent - start_items < RAND_ITEMS) begin
                pick = $urandom_range(0, 9);
                if (pick < 8) begin
                    send_char(rand_code(), 1'b0, 1'($urandom_range(0, 1)), 2);
                end else if (pick == 8) begin
                    send_char(rand_code(), 1'b1, 1'b1, 2);
                end else begin
                    repeat ($urandom_range(1, 3)) begin
                        send_item(1'($urandom_range(0, 1)), $urandom_range(0, 65535));
                    end
                end
                // idle mark between characters now and then
                if ($urandom_range(0, 3) == 0) begin
                    send_item(1'b0, sym * $urandom_range(1, 3));
                end
            end
        end
        wait_idle();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    // back to back, so the drain of the result buffer holds and the input stalls
    task automatic test_output_stall();
        set_timing(1000, 200);
        rx_hold  = LONG_HOLD;
        tx_burst = 1000;
        repeat (14) send_char(rand_code(), 1'b0, 1'b0, 1);
        send_item(1'b1, 1000);
        tx_burst = 0;
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, checks against the oldest due character
    // ------------------------------------------------------------------

    initial begin : rx_side
        t_baudot due;
        int      hold;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                hold    = rx_hold;
                rx_hold = 0;
            end else begin
                hold = pick_wait(rx_burst);
            end
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            if (baudot_due.size() == 0) begin
                $error("baudot_code: nothing expected, got %0d", out_ch.baudot_code);
                n_errors++;
            end else begin
                due = baudot_due.pop_front();
                if (out_ch.baudot_code !== due.code) begin
                    $error("baudot_code: expected %0d, got %0d", due.code, out_ch.baudot_code);
                    n_errors++;
                end
                if (out_ch.last_of_run !== due.last) begin
                    $error("last_of_run: expected %0d, got %0d", due.last, out_ch.last_of_run);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.level_is_space <= 1'b0;
        in_ch.elapsed_ticks  <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= REG_SYMBOL;
        cfg_ch.data          <= '0;

        // predictor state after reset
        sym_ticks   = SYM_RESET;
        sw_ticks    = SW_RESET;
        on_mark     = 1'b1;
        pend_ticks  = 32'd0;
        mark_ticks  = 32'd0;
        space_ticks = 32'd0;
        hist        = '0;
        nbits       = 5'd0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_timing_extremes();
        test_random_traffic();
        test_output_stall();
        wait_idle();

        if (n_errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
